// ===== design/scalar_mod_order_multiply_reduce_assert.svh =====
// Assertion macros shared by the scalar modular multiply-reduce RTL.
`ifndef SCALAR_MOD_ORDER_MULTIPLY_REDUCE_ASSERT_SVH
`define SCALAR_MOD_ORDER_MULTIPLY_REDUCE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SMMR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smmr same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SMMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smmr next-cycle check failed");

`endif

// ===== design/smmr_pkg.sv =====
// Constants for the scalar unit modulo the Ed25519 group order.
`timescale 1ns / 1ps
`default_nettype none
package smmr_pkg;

   // group order m = 2^252 + c
   localparam int ORDER_W = 253;
   localparam int C_W     = 125;
   localparam logic [ORDER_W-1:0] ORDER_M =
      253'h1000000000000000000000000000000014DEF9DEA2F79CD65812631A5CF5D3ED;
   localparam logic [C_W-1:0] ORDER_C = 125'h14DEF9DEA2F79CD65812631A5CF5D3ED;

   // widths of the folding chain
   localparam int LOW_W    = 252;
   localparam int X0_W     = 512;
   localparam int X1_W     = 387;
   localparam int X2_W     = 262;
   localparam int X3_W     = 254;

   // multiples of m that keep each fold non-negative
   localparam logic [X1_W-1:0] FOLD1_BIAS = {1'b0, ORDER_M, 133'b0};
   localparam logic [X2_W-1:0] FOLD2_BIAS = {1'b0, ORDER_M, 8'b0};
   localparam logic [X3_W-1:0] FOLD3_BIAS = {1'b0, ORDER_M};

endpackage
`default_nettype wire

// ===== design/smmr_mul.sv =====
// Pipelined wide multiplier built from 32x32 partial products with a tag lane.
`timescale 1ns / 1ps
`default_nettype none
module smmr_mul #(
   parameter int A_W = 125,
   parameter int B_W = 260,
   parameter int T_W = 252
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [A_W-1:0]       in_a,
   input  logic [B_W-1:0]       in_b,
   input  logic [T_W-1:0]       in_tag,
   output logic                 out_valid,
   output logic [A_W+B_W-1:0]   out_p,
   output logic [T_W-1:0]       out_tag
);
   import smmr_pkg::*;

   localparam int NA     = (A_W + 31) / 32;
   localparam int NB     = (B_W + 31) / 32;
   localparam int PW     = 32 * (NA + NB);
   localparam int LEVELS = $clog2(NA);
   localparam int DEPTH  = 3 + LEVELS;

   function automatic int level_count(input int l);
      return (NA + (1 << l) - 1) >> l;
   endfunction

   logic [32*NA-1:0] a_ff;
   logic [32*NB-1:0] b_ff;
   logic [63:0]      prod_ff [NA][NB];
   logic [PW-1:0]    even_v  [NA];
   logic [PW-1:0]    odd_v   [NA];
   logic [PW-1:0]    lvl_ff  [LEVELS+1][NA];
   logic [T_W-1:0]   tag_ff  [DEPTH];
   logic             valid_ff[DEPTH];

   // lay out each row: even and odd products do not overlap
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         even_v[i] = '0;
         odd_v[i]  = '0;
         for (int j = 0; j < NB; j++) begin
            if ((j & 1) == 1) begin
               odd_v[i][32*j +: 64] = prod_ff[i][j];
            end else begin
               even_v[i][32*j +: 64] = prod_ff[i][j];
            end
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < DEPTH; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // advance operands, partial products, rows and the row tree
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff      <= (32*NA)'(in_a);
         b_ff      <= (32*NB)'(in_b);
         tag_ff[0] <= in_tag;
         for (int s = 1; s < DEPTH; s++) tag_ff[s] <= tag_ff[s-1];
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               prod_ff[i][j] <= 64'(a_ff[32*i +: 32]) * 64'(b_ff[32*j +: 32]);
            end
            lvl_ff[0][i] <= even_v[i] + odd_v[i];
         end
         for (int l = 1; l <= LEVELS; l++) begin
            for (int k = 0; k < NA; k++) begin
               if (2*k + 1 < level_count(l-1)) begin
                  lvl_ff[l][k] <= lvl_ff[l-1][2*k]
                     + (lvl_ff[l-1][2*k+1] << (32 * (1 << (l-1))));
               end else if (2*k < level_count(l-1)) begin
                  lvl_ff[l][k] <= lvl_ff[l-1][2*k];
               end else begin
                  lvl_ff[l][k] <= '0;
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_tag   = tag_ff[DEPTH-1];
   assign out_p     = lvl_ff[LEVELS][0][A_W+B_W-1:0];

endmodule
`default_nettype wire

// ===== design/scalar_mod_order_multiply_reduce.sv =====
// Throughput: one beat per cycle unless a response stall holds the pipeline; the
// 256x256 product and three folding multiplies by the low part of the order are
// each a pipeline of 32x32 products. A response stall while a response beat is
// valid freezes the whole pipeline in place, bubbles included.
// Reset (synchronous, active high) clears all valid bits; data carry no reset.
`timescale 1ns / 1ps
`default_nettype none
module scalar_mod_order_multiply_reduce #(
   parameter int LIMB_BITS = 52
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [6:0]  req_byte_count,
   input  logic [63:0] req_word0,
   input  logic [63:0] req_word1,
   input  logic [63:0] req_word2,
   input  logic [63:0] req_word3,
   input  logic [63:0] req_word4,
   input  logic [63:0] req_word5,
   input  logic [63:0] req_word6,
   input  logic [63:0] req_word7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_w0,
   output logic [63:0] rsp_result_w1,
   output logic [63:0] rsp_result_w2,
   output logic [60:0] rsp_result_w3
);
   import smmr_pkg::*;

   localparam int LIMB_COUNT = (253 + LIMB_BITS - 1) / LIMB_BITS;
   localparam int LIMB_SPAN  = LIMB_COUNT * LIMB_BITS;
   localparam int OPND_BITS  = (LIMB_SPAN < 256) ? LIMB_SPAN : 256;
   localparam int VALUE_BITS = (2 * LIMB_SPAN < 512) ? 2 * LIMB_SPAN : 512;
   localparam logic [255:0] OPND_MASK  = {256{1'b1}} >> (256 - OPND_BITS);
   localparam logic [511:0] VALUE_MASK = {512{1'b1}} >> (512 - VALUE_BITS);

   logic                 advance;
   logic [511:0]         byte_mask;
   logic [255:0]         opnd_a;
   logic [255:0]         opnd_b;
   logic [512:0]         m0_tag_in;

   logic                 m0_valid;
   logic [511:0]         m0_p;
   logic [512:0]         m0_tag;
   logic [X0_W-1:0]      x0;

   logic                 m1_valid;
   logic [384:0]         m1_p;
   logic [X1_W-1:0]      m1_tag;
   logic [X1_W-1:0]      x1_in;
   logic [X1_W-1:0]      x1_ff;
   logic                 x1_valid_ff;

   logic                 m2_valid;
   logic [259:0]         m2_p;
   logic [X2_W-1:0]      m2_tag;
   logic [X2_W-1:0]      x2_in;
   logic [X2_W-1:0]      x2_ff;
   logic                 x2_valid_ff;

   logic                 m3_valid;
   logic [134:0]         m3_p;
   logic [X3_W-1:0]      m3_tag;
   logic [X3_W-1:0]      x3_in;
   logic [X3_W-1:0]      x3_ff;
   logic                 x3_valid_ff;

   logic [ORDER_W-1:0]   result_in;
   logic [ORDER_W-1:0]   result_ff;
   logic                 rsp_valid_ff;

   // hold every stage while the response beat waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // keep only the low bytes of a value to reduce
   always_comb begin
      for (int b = 0; b < 64; b++) begin
         byte_mask[8*b +: 8] = (req_byte_count > 7'(b)) ? 8'hFF : 8'h00;
      end
   end

   assign opnd_a    = {req_word3, req_word2, req_word1, req_word0} & OPND_MASK;
   assign opnd_b    = {req_word7, req_word6, req_word5, req_word4} & OPND_MASK;
   assign m0_tag_in = {req_kind,
                       {req_word7, req_word6, req_word5, req_word4,
                        req_word3, req_word2, req_word1, req_word0}
                       & VALUE_MASK & byte_mask};

   // full product a*b; a value to reduce rides along in the tag
   smmr_mul #(.A_W(256), .B_W(256), .T_W(513)) u_mul_ab (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_a      (opnd_a),
      .in_b      (opnd_b),
      .in_tag    (m0_tag_in),
      .out_valid (m0_valid),
      .out_p     (m0_p),
      .out_tag   (m0_tag)
   );

   assign x0 = m0_tag[512] ? m0_tag[511:0] : m0_p;

   // first fold: high part times c, subtracted from low part plus a bias
   smmr_mul #(.A_W(C_W), .B_W(260), .T_W(X1_W)) u_fold1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m0_valid),
      .in_a      (ORDER_C),
      .in_b      (x0[511:LOW_W]),
      .in_tag    (X1_W'(x0[LOW_W-1:0]) + FOLD1_BIAS),
      .out_valid (m1_valid),
      .out_p     (m1_p),
      .out_tag   (m1_tag)
   );

   assign x1_in = m1_tag - X1_W'(m1_p);

   // second fold
   smmr_mul #(.A_W(C_W), .B_W(135), .T_W(X2_W)) u_fold2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (x1_valid_ff),
      .in_a      (ORDER_C),
      .in_b      (x1_ff[X1_W-1:LOW_W]),
      .in_tag    (X2_W'(x1_ff[LOW_W-1:0]) + FOLD2_BIAS),
      .out_valid (m2_valid),
      .out_p     (m2_p),
      .out_tag   (m2_tag)
   );

   assign x2_in = m2_tag - X2_W'(m2_p);

   // third fold leaves a value below 2m
   smmr_mul #(.A_W(10), .B_W(C_W), .T_W(X3_W)) u_fold3 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (x2_valid_ff),
      .in_a      (x2_ff[X2_W-1:LOW_W]),
      .in_b      (ORDER_C),
      .in_tag    (X3_W'(x2_ff[LOW_W-1:0]) + FOLD3_BIAS),
      .out_valid (m3_valid),
      .out_p     (m3_p),
      .out_tag   (m3_tag)
   );

   assign x3_in = m3_tag - X3_W'(m3_p);

   // drop one m if the value is not below it
   assign result_in = (x3_ff >= X3_W'(ORDER_M)) ? ORDER_W'(x3_ff - X3_W'(ORDER_M))
                                                : ORDER_W'(x3_ff);

   // advance fold valid bits and the response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_valid_ff  <= 1'b0;
         x2_valid_ff  <= 1'b0;
         x3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         x1_valid_ff  <= m1_valid;
         x2_valid_ff  <= m2_valid;
         x3_valid_ff  <= m3_valid;
         rsp_valid_ff <= x3_valid_ff;
      end
   end

   // advance fold data and the result
   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff     <= x1_in;
         x2_ff     <= x2_in;
         x3_ff     <= x3_in;
         result_ff <= result_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_w0 = result_ff[63:0];
   assign rsp_result_w1 = result_ff[127:64];
   assign rsp_result_w2 = result_ff[191:128];
   assign rsp_result_w3 = result_ff[252:192];

`include "scalar_mod_order_multiply_reduce_assert.svh"

   `SMMR_ASSERT_SAME(a_result_reduced, rsp_valid_ff, result_ff < ORDER_M)
   `SMMR_ASSERT_SAME(a_fold_below_twice, x3_valid_ff,
      x3_ff < (X3_W'(ORDER_M) << 1))
   `SMMR_ASSERT_NEXT(a_fold_advances, advance && m3_valid, x3_valid_ff)

endmodule
`default_nettype wire

// ===== tb/scalar_mod_order_multiply_reduce_tb.sv =====
// Self-checking testbench for the scalar multiply-reduce unit modulo the Ed25519 order.
`timescale 1ns / 1ps
`default_nettype none
module scalar_mod_order_multiply_reduce_tb;
   import smmr_pkg::*;

   localparam int KIND_MUL = 0;
   localparam int KIND_RED = 1;
   localparam int RANDOM_ITEMS = 1630;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic        kind;
      logic [6:0]  byte_count;
      logic [63:0] w [8];
   } scalar_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [6:0]  req_byte_count;
   logic [63:0] req_word0, req_word1, req_word2, req_word3;
   logic [63:0] req_word4, req_word5, req_word6, req_word7;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_w0, rsp_result_w1, rsp_result_w2;
   logic [60:0] rsp_result_w3;

   scalar_req_type pending_reqs [$];
   logic [252:0]   expected_residues [$];
   int             mismatch_count;
   int             issued_count;
   bit             stimulus_done;
   bit             quiet_phase;
   int             hold_off_cycles;

   scalar_mod_order_multiply_reduce i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_byte_count(req_byte_count),
      .req_word0(req_word0), .req_word1(req_word1),
      .req_word2(req_word2), .req_word3(req_word3),
      .req_word4(req_word4), .req_word5(req_word5),
      .req_word6(req_word6), .req_word7(req_word7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_w0(rsp_result_w0), .rsp_result_w1(rsp_result_w1),
      .rsp_result_w2(rsp_result_w2), .rsp_result_w3(rsp_result_w3)
   );

   // Compute the exact residue of one request modulo the group order.
   function automatic logic [252:0] order_residue(scalar_req_type r);
      logic [511:0] value;
      logic [255:0] opa, opb;
      int           nbits;
      value = '0;
      if (r.kind == 1'(KIND_MUL)) begin
         opa = {r.w[3], r.w[2], r.w[1], r.w[0]};
         opb = {r.w[7], r.w[6], r.w[5], r.w[4]};
         value = 512'(opa) * 512'(opb);
      end else begin
         nbits = (r.byte_count > 7'd64) ? 512 : int'(r.byte_count) * 8;
         value = {r.w[7], r.w[6], r.w[5], r.w[4], r.w[3], r.w[2], r.w[1], r.w[0]};
         if (nbits < 512)
            value &= (512'd1 << nbits) - 512'd1;
      end
      return 253'(value % 512'(ORDER_M));
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Pick a word biased toward the edges of its range.
   function automatic logic [63:0] edgy_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'(ORDER_M >> (64 * $urandom_range(0, 3)));
         default: return rand64();
      endcase
   endfunction

   task automatic push_req(logic kind, logic [6:0] count, logic [63:0] w [8]);
      scalar_req_type r;
      r.kind = kind;
      r.byte_count = count;
      r.w = w;
      pending_reqs.push_back(r);
   endtask

   // Clock and reset.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Fill the request queue: directed cases first, then random ones.
   initial begin
      logic [63:0] w [8];
      logic [252:0] mm1;
      mm1 = ORDER_M - 253'd1;
      stimulus_done = 1'b0;
      foreach (w[i]) w[i] = '0;
      push_req(1'(KIND_MUL), 7'd0, w);
      push_req(1'(KIND_RED), 7'd64, w);
      foreach (w[i]) w[i] = '1;
      push_req(1'(KIND_MUL), 7'd127, w);
      push_req(1'(KIND_RED), 7'd64, w);
      push_req(1'(KIND_RED), 7'd127, w);
      push_req(1'(KIND_RED), 7'd65, w);
      push_req(1'(KIND_RED), 7'd0, w);
      push_req(1'(KIND_RED), 7'd1, w);
      push_req(1'(KIND_RED), 7'd32, w);
      push_req(1'(KIND_RED), 7'd63, w);
      // operands equal to m and to m - 1
      {w[3], w[2], w[1], w[0]} = 256'(ORDER_M);
      {w[7], w[6], w[5], w[4]} = 256'(mm1);
      push_req(1'(KIND_MUL), 7'd5, w);
      push_req(1'(KIND_RED), 7'd32, w);
      {w[3], w[2], w[1], w[0]} = 256'(mm1);
      push_req(1'(KIND_MUL), 7'd0, w);
      push_req(1'(KIND_RED), 7'd32, w);
      {w[7], w[6], w[5], w[4]} = 256'd1;
      push_req(1'(KIND_MUL), 7'd0, w);
      push_req(1'(KIND_RED), 7'd64, w);
      // random mix with edge-biased words and byte counts
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         foreach (w[i]) w[i] = edgy_word();
         push_req(1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 64)), w);
      end
      stimulus_done = 1'b1;
   end

   // Drive request beats from the queue, with random idle bursts.
   int req_idle;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_kind <= 1'b0;
         req_byte_count <= '0;
         {req_word0, req_word1, req_word2, req_word3} <= '0;
         {req_word4, req_word5, req_word6, req_word7} <= '0;
         req_idle <= 0;
         issued_count <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid)
            issued_count <= issued_count + 1;
         if (req_idle > 0) begin
            req_valid <= 1'b0;
            req_idle <= req_idle - 1;
         end else if (pending_reqs.size() > 0) begin
            scalar_req_type r;
            r = pending_reqs.pop_front();
            expected_residues.push_back(order_residue(r));
            req_valid <= 1'b1;
            req_kind <= r.kind;
            req_byte_count <= r.byte_count;
            req_word0 <= r.w[0]; req_word1 <= r.w[1];
            req_word2 <= r.w[2]; req_word3 <= r.w[3];
            req_word4 <= r.w[4]; req_word5 <= r.w[5];
            req_word6 <= r.w[6]; req_word7 <= r.w[7];
            if (!quiet_phase && $urandom_range(0, 7) == 0)
               req_idle <= $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Drive the response stall: random bursts plus one long hold-off.
   int rsp_burst;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_burst <= 0;
         hold_off_cycles <= 0;
      end else if (issued_count >= 300 && issued_count < 302 && hold_off_cycles == 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= 1;
      end else if (hold_off_cycles > 0 && hold_off_cycles < 80) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles + 1;
      end else if (rsp_burst > 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= rsp_burst - 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         rsp_burst <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   assign quiet_phase = stimulus_done && pending_reqs.size() < 150;

   // Check each response beat against the oldest expected residue.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_residues.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected response beat: %h %h %h %h",
                        rsp_result_w3, rsp_result_w2, rsp_result_w1, rsp_result_w0);
         end else begin
            logic [252:0] exp_r;
            exp_r = expected_residues.pop_front();
            if (rsp_result_w0 !== exp_r[63:0] || rsp_result_w1 !== exp_r[127:64] ||
                rsp_result_w2 !== exp_r[191:128] || rsp_result_w3 !== exp_r[252:192]) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("residue mismatch: expected %h got %h_%h_%h_%h", exp_r,
                           rsp_result_w3, rsp_result_w2, rsp_result_w1, rsp_result_w0);
            end
         end
      end
   end

   // Wait for the queues to drain, then report.
   initial begin
      mismatch_count = 0;
      wait (stimulus_done);
      wait (pending_reqs.size() == 0 && !req_valid && expected_residues.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_residues.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/smmr_pkg.sv
design/smmr_mul.sv
design/scalar_mod_order_multiply_reduce.sv
tb/scalar_mod_order_multiply_reduce_tb.sv
